// ----- hw/rtl/b64lw_pkg.sv -----
// Shared types, constants and the symbol table for the Base64 line-wrapping encoder.
// No dependencies; the front end, back end and top level import this package.
package b64lw_pkg;

  localparam int GRP_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 2;

  localparam logic [6:0] CHAR_PLUS    = 7'd43;
  localparam logic [6:0] CHAR_SLASH   = 7'd47;
  localparam logic [6:0] CHAR_PAD     = 7'd61;
  localparam logic [6:0] CHAR_NEWLINE = 7'd10;
  localparam logic [7:0] MIN_LINE     = 8'd4;
  localparam logic [7:0] COL_MAX      = 8'd255;
  localparam logic [7:0] LINE_LEN_RST = 8'd76;

  // configuration register indexes
  localparam logic CFG_IDX_ENABLE = 1'b0;
  localparam logic CFG_IDX_LENGTH = 1'b1;

  // leftover bit counts
  localparam logic [1:0] LEFT_NONE = 2'd0;
  localparam logic [1:0] LEFT_TWO  = 2'd1;
  localparam logic [1:0] LEFT_FOUR = 2'd2;

  // one group of up to four characters produced by one input byte
  typedef struct packed {
    logic [3:0][6:0] chars;
    logic [2:0]      cnt;
    logic            last;
  } grp_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } out_t;

  typedef struct packed {
    logic       enable;
    logic [7:0] length;
  } cfg_t;

  function automatic logic [6:0] sym_of(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'd71 + {1'b0, v};
    end else if (v < 6'd62) begin
      r = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      r = CHAR_PLUS;
    end else begin
      r = CHAR_SLASH;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/b64lw_fifo.sv -----
// Small first-in first-out queue of fixed-width words, used between the stages.
// Depends on nothing; width and depth come from the instantiating module.
module b64lw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/b64lw_front.sv -----
// Front end: takes one byte per word, splits it into its group of symbols and pads.
// Depends on b64lw_pkg for the group type and the symbol table.
module b64lw_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output b64lw_pkg::grp_t   grp,
  output logic              grp_push
);
  import b64lw_pkg::*;

  logic [3:0] left_bits_r, left_bits_nxt;
  logic [1:0] left_cnt_r, left_cnt_nxt;

  assign grp_push = in_valid;

  always_comb begin
    grp           = '0;
    grp.last      = last_byte;
    left_bits_nxt = left_bits_r;
    left_cnt_nxt  = left_cnt_r;
    case (left_cnt_r)
      LEFT_TWO: begin
        grp.chars[0]  = sym_of({left_bits_r[1:0], data_byte[7:4]});
        grp.chars[1]  = sym_of({data_byte[3:0], 2'b00});
        grp.chars[2]  = CHAR_PAD;
        grp.cnt       = last_byte ? 3'd3 : 3'd1;
        left_bits_nxt = data_byte[3:0];
        left_cnt_nxt  = LEFT_FOUR;
      end
      LEFT_FOUR: begin
        grp.chars[0]  = sym_of({left_bits_r, data_byte[7:6]});
        grp.chars[1]  = sym_of(data_byte[5:0]);
        grp.cnt       = 3'd2;
        left_bits_nxt = '0;
        left_cnt_nxt  = LEFT_NONE;
      end
      default: begin
        // no bits pending (an impossible count is taken as none)
        grp.chars[0]  = sym_of(data_byte[7:2]);
        grp.chars[1]  = sym_of({data_byte[1:0], 4'b0000});
        grp.chars[2]  = CHAR_PAD;
        grp.chars[3]  = CHAR_PAD;
        grp.cnt       = last_byte ? 3'd4 : 3'd1;
        left_bits_nxt = {2'b00, data_byte[1:0]};
        left_cnt_nxt  = LEFT_TWO;
      end
    endcase
    if (last_byte) begin
      left_bits_nxt = '0;
      left_cnt_nxt  = LEFT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_bits_r <= '0;
      left_cnt_r  <= LEFT_NONE;
    end else if (in_valid) begin
      left_bits_r <= left_bits_nxt;
      left_cnt_r  <= left_cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/b64lw_back.sv -----
// Back end: issues one character a cycle from the head group while the output queue has room, inserting line breaks.
// Depends on b64lw_pkg for the group, result and configuration types.
module b64lw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  b64lw_pkg::cfg_t   cfg,
  input  b64lw_pkg::grp_t   grp,
  input  logic              grp_avail,
  output logic              grp_pop,
  output b64lw_pkg::out_t   res,
  output logic              res_push,
  input  logic              res_full
);
  import b64lw_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic [7:0] col_r, col_nxt;
  logic [7:0] limit;
  logic       brk;
  logic       tail;

  assign limit    = (cfg.length < MIN_LINE) ? MIN_LINE : cfg.length;
  assign brk      = cfg.enable && (col_r >= limit);
  assign tail     = ({1'b0, idx_r} == (grp.cnt - 3'd1));
  assign res_push = grp_avail && !res_full;
  assign grp_pop  = res_push && !brk && tail;

  always_comb begin
    idx_nxt  = idx_r;
    col_nxt  = col_r;
    res.ch   = grp.chars[idx_r];
    res.last = grp.last && tail;
    if (brk) begin
      res.ch   = CHAR_NEWLINE;
      res.last = 1'b0;
    end
    if (res_push) begin
      if (brk) begin
        col_nxt = '0;
      end else begin
        col_nxt = (col_r < COL_MAX) ? col_r + 8'd1 : col_r;
        if (tail) begin
          idx_nxt = '0;
          if (grp.last) begin
            col_nxt = '0;
          end
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      col_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// ----- hw/rtl/base64_encoder_line_wrap.sv -----
// Top level of the Base64 encoder with optional line wrapping.
// Depends on b64lw_pkg, b64lw_fifo, b64lw_front and b64lw_back.

// Bytes go in through a queue-style port (push/full) and Base64 characters come out of
// another (empty/pop), with '=' padding after the final byte and, when wrapping is on,
// a newline before any character once the configured line length (at least 4) stands
// on the line; no newline follows the last character. Each accepted byte turns into
// one to five characters: one or two in mid message, three when a line break falls
// among them, up to five at the end of a message with a line break. The block delivers
// one character per cycle while the output queue has room and a group is waiting; the
// character issue of the back end sets that pace, and the group queue in front of it
// lets bytes be taken while characters of earlier bytes are still being issued. Write
// the configuration registers only while the block is idle; cfg_ready is always high.
// There is no clearing pass after reset.
module base64_encoder_line_wrap #(
  parameter int GRP_DEPTH = b64lw_pkg::GRP_DEPTH_DEF,
  parameter int OUT_DEPTH = b64lw_pkg::OUT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // byte input
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  // character output
  output logic       out_empty,
  input  logic       out_pop,
  output logic [6:0] out_char,
  output logic       out_last_char,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import b64lw_pkg::*;

  localparam int GRP_W = $bits(grp_t);
  localparam int OUT_W = $bits(out_t);

  cfg_t             cfg_r;
  grp_t             gp_word;
  logic             gp_push;
  logic             gf_full;
  logic             gf_empty;
  logic [GRP_W-1:0] gf_rdata;
  grp_t             gf_head;
  logic             bk_grp_pop;
  out_t             bk_res;
  logic             bk_push;
  logic             of_full;
  logic [OUT_W-1:0] of_rdata;
  out_t             of_head;

  // configuration registers: always ready, take the word at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable <= 1'b0;
      cfg_r.length <= LINE_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_ENABLE: cfg_r.enable <= cfg_data[0];
        CFG_IDX_LENGTH: cfg_r.length <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end: accept a byte whenever the group queue has room
  assign in_full = gf_full;

  b64lw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_push && !in_full),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .grp       (gp_word),
    .grp_push  (gp_push)
  );

  // group queue decouples byte intake from character issue
  b64lw_fifo #(
    .WIDTH (GRP_W),
    .DEPTH (GRP_DEPTH)
  ) u_grp_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (gp_push),
    .wdata (gp_word),
    .full  (gf_full),
    .pop   (bk_grp_pop),
    .rdata (gf_rdata),
    .empty (gf_empty)
  );

  assign gf_head = grp_t'(gf_rdata);

  // back end: one character per cycle while the output queue has room, line breaks inserted here
  b64lw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .grp       (gf_head),
    .grp_avail (!gf_empty),
    .grp_pop   (bk_grp_pop),
    .res       (bk_res),
    .res_push  (bk_push),
    .res_full  (of_full)
  );

  // output queue: hold finished characters until popped
  b64lw_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bk_push),
    .wdata (bk_res),
    .full  (of_full),
    .pop   (out_pop),
    .rdata (of_rdata),
    .empty (out_empty)
  );

  assign of_head       = out_t'(of_rdata);
  assign out_char      = of_head.ch;
  assign out_last_char = of_head.last;

`ifndef SYNTH
  a_grp_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    gp_push |-> (gp_word.cnt != 3'd0 && gp_word.cnt <= 3'd4))
    else $error("group with impossible character count");

  a_grp_pop_sane: assert property (@(posedge clk) disable iff (!rst_n)
    bk_grp_pop |-> (!gf_empty && bk_push))
    else $error("group retired without issuing its final character");

  a_last_ends_grp: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_push && bk_res.last) |-> bk_grp_pop)
    else $error("final character issued but group not retired");
`endif

endmodule
